[sv/ice_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the ICMP echo checksum block.
// No dependencies; used by every module of the block.
package ice_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 2);

  localparam logic [15:0] TYPE_CODE_WORD = 16'h0008;
  localparam logic [15:0] ID_RESET       = 16'h0125;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_ECHO_ID = 3'd0;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [15:0] checksum_word;
    logic [15:0] sequence_used;
    logic        too_long;
  } result_t;

  // add with end-around carry, inputs already folded to 16 bits
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    oc_add = t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

[sv/icmp_echo_checksum.sv]
`timescale 1ns / 1ps
// Top level of the ICMP echo checksum block: register port and the two stages.
// Depends on ice_pkg, ice_in_stage and ice_accum.
//
// Takes one payload byte per beat and emits one result beat per packet, on the
// beat marked last. A new beat is taken every cycle; each byte pair adds one
// word to the running sum, and the close folds payload and header words in one
// pass, so the only wait comes from a result still stalled in the output
// register when the next packet's last beat is ready. The result is registered
// when the last beat leaves the input register. A packet over 1024 bytes
// returns too_long with a zero checksum and leaves the sequence number as is.
// The identifier register sits at byte address 0 and resets to 0x125.
module icmp_echo_checksum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_payload_byte,
  input  logic                          in_byte_present,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_checksum_word,
  output logic [15:0]                   out_sequence_used,
  output logic                          out_too_long,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ice_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [15:0]      echo_id_r;
  ice_pkg::item_t   in_item;
  ice_pkg::item_t   item;
  ice_pkg::result_t result;
  logic             item_vld;
  logic             consume;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ice_pkg::REG_ECHO_ID) ? {16'd0, echo_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_id_r <= ice_pkg::ID_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr == ice_pkg::REG_ECHO_ID) begin
      echo_id_r <= cfg_pwdata[15:0];
    end
  end

  assign in_item.payload_byte = in_payload_byte;
  assign in_item.byte_present = in_byte_present;
  assign in_item.is_last      = in_is_last;

  ice_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .item_vld (item_vld),
    .item     (item),
    .consume  (consume)
  );

  ice_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .consume   (consume),
    .echo_id   (echo_id_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_checksum_word = result.checksum_word;
  assign out_sequence_used = result.sequence_used;
  assign out_too_long      = result.too_long;

endmodule

[sv/ice_in_stage.sv]
`timescale 1ns / 1ps
// Input register of the ICMP echo checksum block.
// Holds one accepted beat until the checksum stage consumes it; uses ice_pkg.
module ice_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ice_pkg::item_t in_item,
  output logic          item_vld,
  output ice_pkg::item_t item,
  input  logic          consume
);

  logic           item_vld_r;
  ice_pkg::item_t item_r;

  assign in_stall = item_vld_r && !consume;
  assign item_vld = item_vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[sv/ice_accum.sv]
`timescale 1ns / 1ps
// Running ones' complement sum, packet close and result register.
// Depends on ice_pkg; fed by ice_in_stage.
module ice_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  ice_pkg::item_t   item,
  output logic             consume,
  input  logic [15:0]      echo_id,
  output logic             out_valid,
  input  logic             out_stall,
  output ice_pkg::result_t result
);

  logic [15:0]              sum_r, sum_nxt;
  logic [7:0]               held_r, held_nxt;
  logic                     odd_r, odd_nxt;
  logic [ice_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [15:0]              seq_r, seq_nxt;
  logic                     out_valid_r, out_valid_nxt;
  ice_pkg::result_t         res_r;

  logic        take_byte;
  logic        pairing;
  logic        too_long;
  logic        close_pkt;
  logic [15:0] pair_word;
  logic [15:0] extra_word;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign consume   = item_vld && !(item.is_last && out_valid_r && out_stall);
  assign close_pkt = consume && item.is_last;

  always_comb begin
    cnt_inc = cnt_r;
    if (item.byte_present && (cnt_r <= ice_pkg::CNT_W'(ice_pkg::MAX_PAYLOAD))) begin
      cnt_inc = cnt_r + 1'b1;
    end
    take_byte = item.byte_present && (cnt_inc <= ice_pkg::CNT_W'(ice_pkg::MAX_PAYLOAD));
    too_long  = cnt_inc > ice_pkg::CNT_W'(ice_pkg::MAX_PAYLOAD);
    pairing   = take_byte && odd_r;
    pair_word = {item.payload_byte, held_r};

    extra_word = 16'd0;
    if (pairing) begin
      extra_word = pair_word;
    end else if (take_byte) begin
      extra_word = {8'd0, item.payload_byte};
    end else if (odd_r) begin
      extra_word = {8'd0, held_r};
    end
    total = {3'd0, sum_r} + {3'd0, extra_word} + {3'd0, ice_pkg::TYPE_CODE_WORD}
          + {3'd0, echo_id} + {3'd0, seq_r};
    fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
  end

  always_comb begin
    sum_nxt  = sum_r;
    held_nxt = held_r;
    odd_nxt  = odd_r;
    cnt_nxt  = cnt_r;
    seq_nxt  = seq_r;
    if (consume) begin
      cnt_nxt = cnt_inc;
      if (pairing) begin
        sum_nxt  = ice_pkg::oc_add(sum_r, pair_word);
        held_nxt = 8'd0;
        odd_nxt  = 1'b0;
      end else if (take_byte) begin
        held_nxt = item.payload_byte;
        odd_nxt  = 1'b1;
      end
      if (item.is_last) begin
        sum_nxt  = 16'd0;
        held_nxt = 8'd0;
        odd_nxt  = 1'b0;
        cnt_nxt  = '0;
        if (!too_long) begin
          seq_nxt = seq_r + 16'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (close_pkt) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 16'd0;
      held_r      <= 8'd0;
      odd_r       <= 1'b0;
      cnt_r       <= '0;
      seq_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      odd_r       <= odd_nxt;
      cnt_r       <= cnt_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (close_pkt) begin
      res_r.checksum_word <= too_long ? 16'd0 : ~fold2;
      res_r.sequence_used <= seq_r;
      res_r.too_long      <= too_long;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  a_close_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    close_pkt |=> out_valid_r)
    else $error("closed packet did not raise a result");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (close_pkt && !too_long) |=> (seq_r == $past(seq_r) + 16'd1))
    else $error("sequence did not advance after a good packet");

  a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (close_pkt && too_long) |=> $stable(seq_r))
    else $error("sequence moved after a rejected packet");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    close_pkt |=> (cnt_r == '0 && !odd_r && sum_r == 16'd0))
    else $error("packet state not cleared at packet end");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ice_pkg::CNT_W'(ice_pkg::MAX_PAYLOAD + 1))
    else $error("byte count beyond saturation");

endmodule
